// ===== sv/lcx_pkg.sv =====
package lcx_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int TIME_W    = 32;
    localparam int TTL_W     = 16;
    localparam int CAP_CFG_W = 4;

    localparam logic [CAP_CFG_W-1:0] CAP_RESET = 4'd8;
    localparam logic [TIME_W-1:0]    TIME_MAX  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_GET  = 2'd0,
        REQ_PUT  = 2'd1,
        REQ_TICK = 2'd2
    } req_t;

    // Broadcast to every entry for the request being processed
    typedef struct packed {
        logic              promote;
        logic              drop;
        logic              insert;
        logic              write;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] expiry;
    } lcx_cmd_t;

    // Status of one entry
    typedef struct packed {
        logic              valid;
        logic              match;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] expiry;
    } lcx_stat_t;

endpackage

// ===== sv/lru_cache_with_expiry_top.sv =====
// Fully associative key/value cache with LRU replacement and a lifetime per
// entry. Requests arrive on the s_ stream (tuser: 0 get, 1 put, 2 tick of the
// internal seconds counter) and each produces exactly one result beat on the
// m_ stream (tuser: found, tdata: value on a live hit, else zero). A request
// is taken into an input register and resolved when the result register is
// free or being read: all ENTRIES keys are compared in parallel, every entry
// updates its own LRU rank and the result register then holds the answer.
// Throughput is one request per clock while m_tready is high. While a result
// waits for m_tready the input register takes one more request and then
// holds s_tready low. Capacity may be changed through cfg_wr_en/cfg_wr_data
// only while the block is idle; zero counts as one and values above ENTRIES
// count as ENTRIES.
module lru_cache_with_expiry_top
    import lcx_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [79:0]          s_tdata,   // lookup_key[31:0], store_value[63:32],
                                            // lifetime[79:64]
    input  logic [1:0]           s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // read_value[31:0]
    output logic                 m_tuser,   // found
    input  logic                 cfg_wr_en,
    input  logic [CAP_CFG_W-1:0] cfg_wr_data
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CAP_W  = (OCC_W > CAP_CFG_W) ? OCC_W : CAP_CFG_W;

    logic [CAP_CFG_W-1:0] cap_reg;
    logic [TIME_W-1:0]    now_reg,  now_next;
    logic [OCC_W-1:0]     occ_reg,  occ_next;

    logic                 in_valid_reg;
    logic [1:0]           req_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     value_reg;
    logic [TTL_W-1:0]     ttl_reg;

    logic                 out_valid_reg;
    logic                 found_reg, found_next;
    logic [VAL_W-1:0]     rdata_reg, rdata_next;

    logic                 proc_fire;
    lcx_cmd_t             cmd;
    lcx_stat_t            lane_stat [ENTRIES];
    logic [RANK_W-1:0]    lane_rank [ENTRIES];
    logic [ENTRIES-1:0]   lane_valid, lane_match, evict_vec, free_vec, fill_vec;

    logic                 hit, hit_expired, need_evict;
    logic [RANK_W-1:0]    hit_rank, last_rank;
    logic [VAL_W-1:0]     hit_value;
    logic [TIME_W-1:0]    hit_expiry, new_expiry;
    logic [TIME_W:0]      expiry_sum;
    logic [CAP_W-1:0]     eff_cap, cap_ext;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg   <= s_tuser;
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
            ttl_reg   <= s_tdata[79:64];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_lane
            lcx_lane #(
                .RANK_W (RANK_W)
            ) u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (proc_fire),
                .cmd      (cmd),
                .ref_rank (hit_rank),
                .sel      (lane_match[gi]),
                .evict    (evict_vec[gi]),
                .fill     (fill_vec[gi]),
                .stat     (lane_stat[gi]),
                .rank     (lane_rank[gi])
            );
            assign lane_valid[gi] = lane_stat[gi].valid;
            assign lane_match[gi] = lane_stat[gi].match;
        end
    endgenerate

    // keys are unique, so at most one lane matches: select by AND-OR
    always_comb begin
        hit_rank   = '0;
        hit_value  = '0;
        hit_expiry = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (lane_match[i]) begin
                hit_rank   = hit_rank   | lane_rank[i];
                hit_value  = hit_value  | lane_stat[i].value;
                hit_expiry = hit_expiry | lane_stat[i].expiry;
            end
        end
    end

    assign hit         = |lane_match;
    assign hit_expired = now_reg > hit_expiry;

    assign cap_ext = CAP_W'(cap_reg);
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CAP_W'(1);
        end else if (cap_ext > CAP_W'(ENTRIES)) begin
            eff_cap = CAP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign need_evict = (CAP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);
    assign last_rank  = RANK_W'(occ_reg - 1'b1);

    // the least recent entry holds the highest rank, occupancy minus one
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            evict_vec[i] = need_evict && lane_valid[i] && (lane_rank[i] == last_rank);
        end
    end

    assign free_vec = ~(lane_valid & ~evict_vec);
    assign fill_vec = free_vec & (~free_vec + ENTRIES'(1));

    assign expiry_sum = {1'b0, now_reg} + (TIME_W + 1)'(ttl_reg);
    assign new_expiry = expiry_sum[TIME_W] ? TIME_MAX : expiry_sum[TIME_W-1:0];

    always_comb begin
        cmd         = '0;
        cmd.key     = key_reg;
        cmd.value   = value_reg;
        cmd.expiry  = new_expiry;
        found_next  = 1'b0;
        rdata_next  = '0;
        now_next    = now_reg;
        occ_next    = occ_reg;
        case (req_reg)
            REQ_GET: begin
                if (hit) begin
                    if (hit_expired) begin
                        cmd.drop = 1'b1;
                        occ_next = OCC_W'(occ_reg - 1'b1);
                    end else begin
                        cmd.promote = 1'b1;
                        found_next  = 1'b1;
                        rdata_next  = hit_value;
                    end
                end
            end
            REQ_PUT: begin
                if (hit) begin
                    cmd.promote = 1'b1;
                    cmd.write   = 1'b1;
                end else begin
                    cmd.insert = 1'b1;
                    if (!need_evict) begin
                        occ_next = OCC_W'(occ_reg + 1'b1);
                    end
                end
            end
            REQ_TICK: begin
                if (now_reg != TIME_MAX) begin
                    now_next = now_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg <= '0;
            occ_reg <= '0;
        end else if (proc_fire) begin
            now_reg <= now_next;
            occ_reg <= occ_next;
        end
    end

    // result register: hold until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            found_reg <= found_next;
            rdata_reg <= rdata_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = found_reg;

    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(lane_valid) == int'(occ_reg))
        else $error("occupancy count disagrees with valid entries");

    a_unique_key: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> $onehot0(lane_match))
        else $error("more than one entry matches the key");

    a_fill_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && cmd.insert) |-> $onehot(fill_vec))
        else $error("insert without exactly one free slot");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> out_valid_reg)
        else $error("processed request left no result beat");

endmodule

// ===== sv/lcx_lane.sv =====
module lcx_lane
    import lcx_pkg::*;
#(
    parameter int RANK_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  lcx_cmd_t          cmd,
    input  logic [RANK_W-1:0] ref_rank,
    input  logic              sel,
    input  logic              evict,
    input  logic              fill,
    output lcx_stat_t         stat,
    output logic [RANK_W-1:0] rank
);

    logic              valid_reg,  valid_next;
    logic [KEY_W-1:0]  key_reg,    key_next;
    logic [VAL_W-1:0]  value_reg,  value_next;
    logic [TIME_W-1:0] expiry_reg, expiry_next;
    logic [RANK_W-1:0] rank_reg,   rank_next;

    always_comb begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        expiry_next = expiry_reg;
        rank_next   = rank_reg;
        if (en) begin
            if (cmd.promote) begin
                if (sel) begin
                    rank_next = '0;
                    if (cmd.write) begin
                        value_next  = cmd.value;
                        expiry_next = cmd.expiry;
                    end
                end else if (valid_reg && rank_reg < ref_rank) begin
                    rank_next = RANK_W'(rank_reg + 1'b1);
                end
            end else if (cmd.drop) begin
                if (sel) begin
                    valid_next = 1'b0;
                end else if (valid_reg && rank_reg > ref_rank) begin
                    rank_next = RANK_W'(rank_reg - 1'b1);
                end
            end else if (cmd.insert) begin
                if (fill) begin
                    valid_next  = 1'b1;
                    key_next    = cmd.key;
                    value_next  = cmd.value;
                    expiry_next = cmd.expiry;
                    rank_next   = '0;
                end else if (evict) begin
                    valid_next = 1'b0;
                end else if (valid_reg) begin
                    // age every surviving entry behind the new one
                    rank_next = RANK_W'(rank_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        value_reg  <= value_next;
        expiry_reg <= expiry_next;
        rank_reg   <= rank_next;
    end

    assign stat.valid  = valid_reg;
    assign stat.match  = valid_reg && (key_reg == cmd.key);
    assign stat.value  = value_reg;
    assign stat.expiry = expiry_reg;
    assign rank        = rank_reg;

endmodule
